### sv/mfu_pkg.sv
// Package for the motor feedback frame unwrap unit: payload structs, the
// stage struct passed to the scaling pipeline, register indexes and reset values.
// No dependencies.
`default_nettype none

package mfu_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_NODE_INDEX  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNTS_REV  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEG_PER_CNT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RPM_PER_CNT = 2'd3;

    localparam logic [3:0]  NODE_INDEX_RESET  = 4'd1;
    localparam logic [15:0] COUNTS_REV_RESET  = 16'd8192;
    localparam logic [31:0] DEG_PER_CNT_RESET = 32'd737280;
    localparam logic [31:0] RPM_PER_CNT_RESET = 32'd480000;

    // Feedback frames use identifiers starting at this base.
    localparam logic [10:0] FRAME_ID_BASE = 11'h200;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [7:0]  byte_zero;
        logic [7:0]  byte_one;
        logic [7:0]  byte_two;
        logic [7:0]  byte_three;
        logic [7:0]  byte_four;
        logic [7:0]  byte_five;
    } in_t;

    typedef struct packed {
        logic               frame_matched;
        logic signed [15:0] angle_count;
        logic signed [15:0] speed_rpm;
        logic signed [15:0] current_milliamp;
        logic signed [31:0] angle_deg_q16;
        logic signed [15:0] step_count;
        logic signed [31:0] total_count;
        logic signed [47:0] total_deg_q16;
        logic signed [47:0] step_speed_rpm_q16;
    } out_t;

    // Per-frame values after the unwrap stage, before any scaling.
    typedef struct packed {
        logic               frame_matched;
        logic signed [15:0] angle_count;
        logic signed [15:0] speed_rpm;
        logic signed [15:0] current_milliamp;
        logic signed [15:0] step_count;
        logic signed [31:0] total_count;
    } track_t;

endpackage

`default_nettype wire

### sv/mfu_scale.sv
// Scaling pipeline of the motor feedback frame unwrap unit: degree and rpm
// products, then floor shift and saturation into the output register.
// Depends on mfu_pkg.
`default_nettype none

module mfu_scale (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           trk_valid,
    output logic                trk_ready,
    input  wire mfu_pkg::track_t trk,
    input  wire logic [31:0]    deg_per_count,
    input  wire logic [31:0]    rpm_per_count,
    output logic                out_valid,
    input  wire logic           out_ready,
    output mfu_pkg::out_t       out_data
);

    logic               prod_valid_reg;
    mfu_pkg::track_t    prod_trk_reg;
    logic signed [39:0] prod_ang_reg;
    logic signed [55:0] prod_tot_reg;
    logic signed [47:0] prod_spd_reg;

    logic               res_valid_reg;
    mfu_pkg::out_t      res_reg;

    logic               res_ready;
    logic               prod_ready;
    logic signed [32:0] deg_s;
    logic signed [32:0] rpm_s;
    logic signed [48:0] p_ang;
    logic signed [64:0] p_tot;
    logic signed [48:0] p_spd;
    logic signed [31:0] ang_sat;
    logic signed [47:0] tot_sat;

    assign res_ready  = !res_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || res_ready;
    assign trk_ready  = prod_ready;

    assign deg_s = $signed({1'b0, deg_per_count});
    assign rpm_s = $signed({1'b0, rpm_per_count});

    // The products always fit in their lower bits, so the degree products'
    // floor shift by eight is a plain part-select of the sign-correct word.
    assign p_ang = $signed(trk.angle_count) * deg_s;
    assign p_tot = $signed(trk.total_count) * deg_s;
    assign p_spd = $signed(trk.step_count) * rpm_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (prod_ready)
        begin
            prod_valid_reg <= trk_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && trk_valid)
        begin
            prod_trk_reg <= trk;
            prod_ang_reg <= p_ang[47:8];
            prod_tot_reg <= p_tot[63:8];
            prod_spd_reg <= p_spd[47:0];
        end
    end

    always_comb
    begin
        if (prod_ang_reg[39:31] == {9{prod_ang_reg[39]}})
        begin
            ang_sat = prod_ang_reg[31:0];
        end
        else if (prod_ang_reg[39])
        begin
            ang_sat = 32'sh8000_0000;
        end
        else
        begin
            ang_sat = 32'sh7FFF_FFFF;
        end

        if (prod_tot_reg[55:47] == {9{prod_tot_reg[55]}})
        begin
            tot_sat = prod_tot_reg[47:0];
        end
        else if (prod_tot_reg[55])
        begin
            tot_sat = 48'sh8000_0000_0000;
        end
        else
        begin
            tot_sat = 48'sh7FFF_FFFF_FFFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            res_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && prod_valid_reg)
        begin
            res_reg.frame_matched      <= prod_trk_reg.frame_matched;
            res_reg.angle_count        <= prod_trk_reg.angle_count;
            res_reg.speed_rpm          <= prod_trk_reg.speed_rpm;
            res_reg.current_milliamp   <= prod_trk_reg.current_milliamp;
            res_reg.angle_deg_q16      <= ang_sat;
            res_reg.step_count         <= prod_trk_reg.step_count;
            res_reg.total_count        <= prod_trk_reg.total_count;
            res_reg.total_deg_q16      <= tot_sat;
            res_reg.step_speed_rpm_q16 <= prod_spd_reg;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

`default_nettype wire

### sv/motor_feedback_frame_unwrap_unit.sv
// Top level of the motor feedback frame unwrap unit: frame match, angle
// latch, wrap-corrected step and multi-turn total, configuration registers.
// Depends on mfu_pkg and mfu_scale.
`default_nettype none

// Channel  Direction  Signals                        Moves
// -------  ---------  -----------------------------  ------------------------------
// in       input      in_valid, in_ready, in_data    one received frame per request
// out      output     out_valid, out_ready, out_data one feedback result per request
// cfg      input      cfg_we, cfg_index, cfg_data    one register write per cycle
//
// Every accepted request yields exactly one result, which is presented on the
// output once it has passed the three register stages and can be taken there
// when the output side is not stalled. A new request can be taken in every cycle
// unless the pipeline is full and stalled. The three register stages are the
// unwrap stage that updates the angle and total state, the multiplier stage,
// and the output register fed by the saturation logic. Reset clears the pipeline,
// the latched words and the total, and loads the registers with their documented
// defaults. When out_ready is low the result holds, the stages behind it fill,
// and in_ready drops only once all three stages hold a request.

module motor_feedback_frame_unwrap_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire mfu_pkg::in_t                      in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output mfu_pkg::out_t                          out_data,
    input  wire logic                              cfg_we,
    input  wire logic [mfu_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [mfu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Configuration registers.
    logic [3:0]  node_index_reg;
    logic [15:0] counts_rev_reg;
    logic [31:0] deg_per_cnt_reg;
    logic [31:0] rpm_per_cnt_reg;

    // Tracking state. The previous angle of the step is always the angle
    // latched before this request, so the latch register serves both roles.
    logic [15:0] angle_reg;
    logic [15:0] speed_reg;
    logic [15:0] current_reg;
    logic        zero_done_reg;
    logic [31:0] total_reg;

    // Unwrap stage register, handed to the scaling pipeline.
    logic            trk_valid_reg;
    mfu_pkg::track_t trk_reg;

    logic               trk_ready;
    logic               accept;
    logic               match;
    logic [15:0]        angle_next;
    logic [15:0]        speed_next;
    logic [15:0]        current_next;
    logic [15:0]        diff;
    logic signed [16:0] diff_x;
    logic signed [16:0] half_x;
    logic [15:0]        step_wrap;
    logic [15:0]        step;
    logic [31:0]        total_next;

    assign in_ready = !trk_valid_reg || trk_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_index_reg  <= mfu_pkg::NODE_INDEX_RESET;
            counts_rev_reg  <= mfu_pkg::COUNTS_REV_RESET;
            deg_per_cnt_reg <= mfu_pkg::DEG_PER_CNT_RESET;
            rpm_per_cnt_reg <= mfu_pkg::RPM_PER_CNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mfu_pkg::REG_NODE_INDEX:  node_index_reg  <= cfg_data[3:0];
                mfu_pkg::REG_COUNTS_REV:  counts_rev_reg  <= cfg_data[15:0];
                mfu_pkg::REG_DEG_PER_CNT: deg_per_cnt_reg <= cfg_data;
                mfu_pkg::REG_RPM_PER_CNT: rpm_per_cnt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A frame is ours when its identifier is the feedback base plus the node.
    assign match = in_data.frame_id == (mfu_pkg::FRAME_ID_BASE + {7'd0, node_index_reg});

    always_comb
    begin
        if (match)
        begin
            angle_next   = {in_data.byte_zero, in_data.byte_one};
            speed_next   = {in_data.byte_two, in_data.byte_three};
            current_next = {in_data.byte_four, in_data.byte_five};
        end
        else
        begin
            angle_next   = angle_reg;
            speed_next   = speed_reg;
            current_next = current_reg;
        end

        // Raw step modulo 2^16, then pulled back by one turn when it reaches
        // past half a turn in either direction.
        diff   = angle_next - angle_reg;
        diff_x = $signed({diff[15], diff});
        half_x = $signed({2'b00, counts_rev_reg[15:1]});

        if (diff_x > half_x)
        begin
            step_wrap = diff - counts_rev_reg;
        end
        else if (diff_x < -half_x)
        begin
            step_wrap = diff + counts_rev_reg;
        end
        else
        begin
            step_wrap = diff;
        end

        // The first frame after reset seeds the total with the angle itself.
        if (zero_done_reg)
        begin
            step       = step_wrap;
            total_next = total_reg + {{16{step_wrap[15]}}, step_wrap};
        end
        else
        begin
            step       = 16'd0;
            total_next = {{16{angle_next[15]}}, angle_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg     <= 16'd0;
            speed_reg     <= 16'd0;
            current_reg   <= 16'd0;
            zero_done_reg <= 1'b0;
            total_reg     <= 32'd0;
            trk_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                angle_reg     <= angle_next;
                speed_reg     <= speed_next;
                current_reg   <= current_next;
                zero_done_reg <= 1'b1;
                total_reg     <= total_next;
            end
            if (in_ready)
            begin
                trk_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            trk_reg.frame_matched    <= match;
            trk_reg.angle_count      <= angle_next;
            trk_reg.speed_rpm        <= speed_next;
            trk_reg.current_milliamp <= current_next;
            trk_reg.step_count       <= step;
            trk_reg.total_count      <= total_next;
        end
    end

    mfu_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .trk_valid     (trk_valid_reg),
        .trk_ready     (trk_ready),
        .trk           (trk_reg),
        .deg_per_count (deg_per_cnt_reg),
        .rpm_per_count (rpm_per_cnt_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data)
    );

    // Once seeded, the unit stays seeded until the next reset.
    a_seed_holds: assert property (@(posedge clk) disable iff (!rst_n)
        zero_done_reg |=> zero_done_reg)
        else $error("seed flag cleared without reset");

    // The seeding request always carries a zero step.
    a_seed_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !zero_done_reg |=> trk_reg.step_count == 16'sd0)
        else $error("seeding request has a nonzero step");

    // A frame for another node leaves the angle alone, so its step is zero.
    a_unmatched_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !match |=> trk_reg.step_count == 16'sd0)
        else $error("unmatched frame produced a step");

    // An empty unwrap stage never refuses a request.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !trk_valid_reg |-> in_ready)
        else $error("input stalled with an empty unwrap stage");

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for motor_feedback_frame_unwrap_unit: frame match,
// angle latch, wrap-corrected step, multi-turn total and the scaled outputs.
// Depends on mfu_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;

    // Quiet cycles (nothing accepted on either channel) before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;
    // Cycles allowed after the last result before the verdict.
    localparam int DRAIN_CYCLES = 8;

    localparam longint DEG32_MAX = 64'sd2147483647;
    localparam longint DEG32_MIN = -64'sd2147483648;
    localparam longint DEG48_MAX = 64'sd140737488355327;
    localparam longint DEG48_MIN = -64'sd140737488355328;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    mfu_pkg::in_t                    in_data   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    mfu_pkg::out_t                   out_data;
    logic                            cfg_we    = 1'b0;
    logic [mfu_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mfu_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shadow copy of the register file, kept in step with every write.
    logic [3:0]  m_node;
    logic [15:0] m_cpr;
    logic [31:0] m_deg;
    logic [31:0] m_rpm;

    // Shadow copy of the tracking state of the unit.
    logic [15:0] m_angle;
    logic [15:0] m_speed;
    logic [15:0] m_current;
    logic [15:0] m_prev;
    logic        m_seeded;
    int          m_total;

    // Results predicted for accepted requests, oldest first.
    mfu_pkg::out_t expected_feedback[$];

    int mismatches    = 0;
    int results_seen  = 0;
    int quiet_cycles  = 0;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    motor_feedback_frame_unwrap_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Takes the low 16 bits of v as a signed word.
    function automatic int wrap16(int v);
        logic signed [15:0] w;
        w = v[15:0];
        return int'(w);
    endfunction

    // Product of a signed count and an unsigned Q8.24 factor, brought to Q16
    // by an arithmetic shift, which rounds toward minus infinity.
    function automatic longint scale_q8(longint a, logic [31:0] b);
        longint p;
        p = a * longint'({32'd0, b});
        return p >>> 8;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Identifier that the unit answers to under the current node index.
    function automatic logic [10:0] own_id();
        return mfu_pkg::FRAME_ID_BASE + {7'd0, m_node};
    endfunction

    // Advances the shadow state by one frame and returns the result it causes.
    function automatic mfu_pkg::out_t predict_feedback(mfu_pkg::in_t f);
        mfu_pkg::out_t r;
        logic          id_hit;
        int            diff;
        int            half;
        int            stp;
        longint        ang_deg;
        longint        tot_deg;
        longint        spd;

        id_hit = (f.frame_id == own_id());
        if (id_hit)
        begin
            m_angle   = {f.byte_zero, f.byte_one};
            m_speed   = {f.byte_two, f.byte_three};
            m_current = {f.byte_four, f.byte_five};
        end

        // The raw difference wraps as a 16-bit word before the half-turn test.
        diff = wrap16(int'(m_angle) - int'(m_prev));
        half = int'(m_cpr >> 1);
        if (diff > half)
            stp = wrap16(diff - int'(m_cpr));
        else if (diff < -half)
            stp = wrap16(diff + int'(m_cpr));
        else
            stp = diff;

        // The very first frame seeds the total with the latched angle itself.
        if (!m_seeded)
        begin
            m_total  = wrap16(int'(m_angle));
            m_seeded = 1'b1;
            stp      = 0;
        end
        else
        begin
            m_total = m_total + stp;
        end
        m_prev = m_angle;

        ang_deg = clamp(scale_q8(longint'(wrap16(int'(m_angle))), m_deg), DEG32_MIN, DEG32_MAX);
        tot_deg = clamp(scale_q8(longint'(m_total), m_deg), DEG48_MIN, DEG48_MAX);
        spd     = longint'(stp) * longint'({32'd0, m_rpm});

        r.frame_matched      = id_hit;
        r.angle_count        = m_angle;
        r.speed_rpm          = m_speed;
        r.current_milliamp   = m_current;
        r.angle_deg_q16      = ang_deg[31:0];
        r.step_count         = stp[15:0];
        r.total_count        = m_total;
        r.total_deg_q16      = tot_deg[47:0];
        r.step_speed_rpm_q16 = spd[47:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR at %0t, result %0d, %s: got %0h, expected %0h",
                 $realtime, results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(mfu_pkg::out_t got);
        mfu_pkg::out_t want;
        if (expected_feedback.size() == 0)
        begin
            report_mismatch("result with no request pending", 64'(got.total_count), 64'd0);
            return;
        end
        want = expected_feedback.pop_front();
        results_seen++;
        if (got.frame_matched !== want.frame_matched)
            report_mismatch("frame_matched", 64'(got.frame_matched), 64'(want.frame_matched));
        if (got.angle_count !== want.angle_count)
            report_mismatch("angle_count", 64'(got.angle_count), 64'(want.angle_count));
        if (got.speed_rpm !== want.speed_rpm)
            report_mismatch("speed_rpm", 64'(got.speed_rpm), 64'(want.speed_rpm));
        if (got.current_milliamp !== want.current_milliamp)
            report_mismatch("current_milliamp", 64'(got.current_milliamp),
                            64'(want.current_milliamp));
        if (got.angle_deg_q16 !== want.angle_deg_q16)
            report_mismatch("angle_deg_q16", 64'(got.angle_deg_q16), 64'(want.angle_deg_q16));
        if (got.step_count !== want.step_count)
            report_mismatch("step_count", 64'(got.step_count), 64'(want.step_count));
        if (got.total_count !== want.total_count)
            report_mismatch("total_count", 64'(got.total_count), 64'(want.total_count));
        if (got.total_deg_q16 !== want.total_deg_q16)
            report_mismatch("total_deg_q16", 64'(got.total_deg_q16), 64'(want.total_deg_q16));
        if (got.step_speed_rpm_q16 !== want.step_speed_rpm_q16)
            report_mismatch("step_speed_rpm_q16", 64'(got.step_speed_rpm_q16),
                            64'(want.step_speed_rpm_q16));
    endtask

    // Result side: a result is taken at an edge where out_valid and out_ready
    // were both high. Both are sampled right at the edge, before any update made
    // by that edge lands, and out_ready is then redrawn for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result(out_data);
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Watchdog: any accepted request, result or register write counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL motor_feedback_frame_unwrap_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Every task is entered and left just after a rising
    // edge, so each nonblocking drive lands on the following edge.
    // ------------------------------------------------------------------

    function automatic mfu_pkg::in_t make_frame(logic [10:0] id, logic [15:0] ang,
                                                logic [15:0] spd, logic [15:0] cur);
        mfu_pkg::in_t f;
        f.frame_id   = id;
        f.byte_zero  = ang[15:8];
        f.byte_one   = ang[7:0];
        f.byte_two   = spd[15:8];
        f.byte_three = spd[7:0];
        f.byte_four  = cur[15:8];
        f.byte_five  = cur[7:0];
        return f;
    endfunction

    // Presents one request and returns at the edge that accepts it. The sender
    // may go idle first; valid is only lowered in a step where it is not raised.
    task automatic send_frame(mfu_pkg::in_t frame);
        if ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < in_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= frame;
        do
            @(posedge clk);
        while (!in_ready);
        expected_feedback.push_back(predict_feedback(frame));
    endtask

    // Holds the sender off until every pending result has come back.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_feedback.size() != 0);
    endtask

    task automatic write_register(logic [mfu_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mfu_pkg::REG_NODE_INDEX:  m_node = value[3:0];
            mfu_pkg::REG_COUNTS_REV:  m_cpr  = value[15:0];
            mfu_pkg::REG_DEG_PER_CNT: m_deg  = value;
            mfu_pkg::REG_RPM_PER_CNT: m_rpm  = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Registers change only with the unit idle, so no request sees a half-written set.
    task automatic apply_settings(logic [31:0] node, logic [31:0] cpr,
                                  logic [31:0] deg, logic [31:0] rpm);
        wait_until_drained();
        write_register(mfu_pkg::REG_NODE_INDEX, node);
        write_register(mfu_pkg::REG_COUNTS_REV, cpr);
        write_register(mfu_pkg::REG_DEG_PER_CNT, deg);
        write_register(mfu_pkg::REG_RPM_PER_CNT, rpm);
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        in_idle_pct   = sender_pct;
        out_stall_pct = receiver_pct;
    endtask

    // Next angle word: mostly a step near the current angle, including the
    // exact half-turn boundaries, sometimes a fresh random word.
    function automatic logic [15:0] random_angle();
        int half;
        int base;
        half = int'(m_cpr >> 1);
        base = int'(m_angle);
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'(base + half);
            2: return 16'(base - half);
            3: return 16'(base + half + 1);
            4: return 16'(base - half - 1);
            default: return 16'(base + int'($urandom_range(2 * half + 4)) - half - 2);
        endcase
    endfunction

    // Mostly the unit's own identifier, then other nodes, then any identifier.
    function automatic logic [10:0] random_frame_id();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return own_id();
        if (r < 80)
            return mfu_pkg::FRAME_ID_BASE + 11'($urandom_range(15));
        return 11'($urandom_range(2047));
    endfunction

    // Counts per turn, leaning on the degenerate and extreme values.
    function automatic logic [15:0] random_counts_per_rev();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd2;
            3: return 16'd32768;
            4: return 16'd65535;
            default: return 16'($urandom_range(32768, 2));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default registers: node 1, 8192 counts per turn, so half a turn is 4096.
    // The first request seeds the total with a negative angle.
    task automatic test_seeding_and_wrap();
        send_frame(make_frame(own_id(), 16'h8001, 16'h7FFF, 16'h8000));
        // Frames for other identifiers latch nothing and step by zero.
        send_frame(make_frame(11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_frame(make_frame(mfu_pkg::FRAME_ID_BASE, 16'h1234, 16'h0000, 16'h0000));
        // Exactly half a turn stays as it is; one more count is wrapped back.
        send_frame(make_frame(own_id(), 16'h9001, 16'h0001, 16'hFFFF));
        send_frame(make_frame(own_id(), 16'hA002, 16'h8000, 16'h7FFF));
        send_frame(make_frame(own_id(), 16'h9002, 16'h1234, 16'h5678));
        send_frame(make_frame(own_id(), 16'h8001, 16'hFEDC, 16'hBA98));
        // Crossing the sign boundary of the angle word is a step of one count.
        send_frame(make_frame(own_id(), 16'h7FFF, 16'h0000, 16'h0000));
        send_frame(make_frame(own_id(), 16'h8000, 16'h0000, 16'h0000));
        send_frame(make_frame(own_id(), 16'h0000, 16'h0000, 16'h0000));
        send_frame(make_frame(own_id(), 16'hFFFF, 16'hFFFF, 16'hFFFF));
    endtask

    // Register extremes: top node index, zero and one counts per turn, zero and
    // full-scale factors so that the angle degree output saturates.
    task automatic test_register_extremes();
        apply_settings(32'd15, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_frame(make_frame(own_id(), 16'h7FFF, 16'h8000, 16'h7FFF));
        send_frame(make_frame(own_id(), 16'h8000, 16'h7FFF, 16'h8000));
        send_frame(make_frame(own_id(), 16'h0000, 16'h0000, 16'h0000));
        send_frame(make_frame(mfu_pkg::FRAME_ID_BASE, 16'h4000, 16'h4000, 16'h4000));

        apply_settings(32'd0, 32'd1, 32'd0, 32'd0);
        send_frame(make_frame(own_id(), 16'h0001, 16'h0001, 16'h0001));
        send_frame(make_frame(own_id(), 16'h0000, 16'h0002, 16'h0002));
        send_frame(make_frame(mfu_pkg::FRAME_ID_BASE + 11'd15, 16'h5555, 16'h5555,
                              16'h5555));

        apply_settings(32'd8, 32'd65535, mfu_pkg::DEG_PER_CNT_RESET,
                       mfu_pkg::RPM_PER_CNT_RESET);
        send_frame(make_frame(own_id(), 16'h7FFF, 16'h0100, 16'hFF00));
        send_frame(make_frame(own_id(), 16'hFFFF, 16'h00FF, 16'h00FF));

        apply_settings(32'd1, 32'd2, 32'd1, 32'd1);
        send_frame(make_frame(own_id(), 16'h0001, 16'hAAAA, 16'h5555));
        send_frame(make_frame(own_id(), 16'h0003, 16'h5555, 16'hAAAA));
        send_frame(make_frame(own_id(), 16'h0002, 16'hC3C3, 16'h3C3C));
    endtask

    // Random traffic under each idling pattern, with fresh registers per phase.
    task automatic test_random_traffic();
        logic [31:0] deg;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_idling(0, 0);
                1: set_idling(76, 0);
                2: set_idling(0, 76);
                default: set_idling(8, 8);
            endcase
            // Small factors keep the degree outputs mostly in range.
            deg = $urandom_range(1) ? 32'($urandom_range(32'h0100_0000)) : 32'($urandom);
            apply_settings($urandom, {16'($urandom), random_counts_per_rev()}, deg, $urandom);
            for (int i = 0; i < 120; i++)
            begin
                // Once, the sender holds off until the pipeline has emptied.
                if (phase == 1 && i == 60)
                    wait_until_drained();
                send_frame(make_frame(random_frame_id(), random_angle(),
                                      16'($urandom), 16'($urandom)));
            end
        end
    endtask

    // With no wrap correction, alternating angles half a word apart step by
    // -32768 every frame, which drives the total far enough down to saturate
    // the multi-turn degree output at full-scale factor.
    task automatic test_total_saturation();
        int sent;
        set_idling(8, 8);
        apply_settings($urandom, 32'd0, 32'hFFFF_FFFF, $urandom);
        sent = 0;
        while (m_total > -9000000 && sent < 600)
        begin
            send_frame(make_frame(own_id(), m_angle + 16'h8000,
                                  16'($urandom), 16'($urandom)));
            sent++;
        end
    endtask

    task automatic finish_run();
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_feedback.size() == 0)
            $display("PASS motor_feedback_frame_unwrap_unit");
        else
            $display("FAIL motor_feedback_frame_unwrap_unit");
        $finish;
    endtask

    initial
    begin
        // Shadow registers and state start at their reset values.
        m_node    = mfu_pkg::NODE_INDEX_RESET;
        m_cpr     = mfu_pkg::COUNTS_REV_RESET;
        m_deg     = mfu_pkg::DEG_PER_CNT_RESET;
        m_rpm     = mfu_pkg::RPM_PER_CNT_RESET;
        m_angle   = '0;
        m_speed   = '0;
        m_current = '0;
        m_prev    = '0;
        m_seeded  = 1'b0;
        m_total   = 0;
        set_idling(0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_seeding_and_wrap();
        test_register_extremes();
        test_random_traffic();
        test_total_saturation();
        finish_run();
    end

endmodule
